// ===== design/qwd_pkg.sv =====
package qwd_pkg;

    typedef enum logic [1:0] {
        FMT_HALF = 2'd0,
        FMT_Q4   = 2'd1,
        FMT_Q8   = 2'd2,
        FMT_NONE = 2'd3
    } fmt_t;

    localparam logic [0:0] REG_FORMAT_MODE   = 1'b0;
    localparam logic [0:0] REG_ELEMENT_COUNT = 1'b1;

    localparam int Q4_WORDS = 8;
    localparam int Q8_WORDS = 16;

    typedef struct packed {
        logic [15:0] scale;
        logic        neg;
        logic [7:0]  mag;
        logic [32:0] index;
        logic        last_of_word;
        logic        half;
    } elem_t;

    // exact half times a signed integer of magnitude up to 128
    function automatic logic [31:0] scaled_bits(input logic [15:0] h, input logic neg,
                                                input logic [7:0] aq);
        logic        sign;
        logic [4:0]  e5;
        logic [9:0]  m;
        logic [10:0] sig;
        logic [18:0] p;
        logic [4:0]  b;
        logic [8:0]  ex;
        logic [41:0] sh;
        sign = h[15] ^ neg;
        e5   = h[14:10];
        m    = h[9:0];
        sig  = (e5 != 5'd0) ? {1'b1, m} : {1'b0, m};
        p    = 19'(sig) * 19'(aq);
        b    = 5'd0;
        for (int i = 0; i < 19; i++)
        begin
            if (p[i])
            begin
                b = 5'(i);
            end
        end
        ex = (e5 != 5'd0) ? (9'(e5) + 9'd102) : 9'd103;
        ex = ex + 9'(b);
        sh = 42'(p) << (5'd23 - b);
        if (e5 == 5'h1F)
        begin
            if (m != 10'd0)
            begin
                scaled_bits = {h[15], 8'hFF, 1'b1, m[8:0], 13'd0};
            end
            else if (aq == 8'd0)
            begin
                scaled_bits = 32'h7FC00000;
            end
            else
            begin
                scaled_bits = {sign, 8'hFF, 23'd0};
            end
        end
        else if (p == 19'd0)
        begin
            scaled_bits = {sign, 31'd0};
        end
        else
        begin
            scaled_bits = {sign, ex[7:0], sh[22:0]};
        end
    endfunction

endpackage

// ===== design/qwd_convert.sv =====
module qwd_convert
    import qwd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  elem_t elem,
    input  logic [31:0] count,
    output logic  out_valid,
    input  logic  out_ready,
    output logic [31:0] value_bits,
    output logic  end_of_item,
    output logic  end_of_tensor
);

    logic out_valid_reg;
    logic [31:0] value_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // keep infinity and NaN payload of a plain half word as is
    always_comb
    begin
        if (elem.half && (elem.scale[14:10] == 5'h1F))
        begin
            value_next = {elem.scale[15], 8'hFF, elem.scale[9:0], 13'd0};
        end
        else
        begin
            value_next = scaled_bits(elem.scale, elem.neg, elem.mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            value_bits    <= value_next;
            end_of_item   <= elem.last_of_word;
            end_of_tensor <= (elem.index == 33'(count) - 33'd1);
        end
    end

endmodule

// ===== design/quantized_weight_dequantizer.sv =====
// Converts a stream of 16-bit words of a half, Q4_0 or Q8_0 tensor into
// float32 bit patterns, at most one value per cycle while the output is
// not stalled. Each word is held in a register and its values are issued
// one per cycle into a single-stage converter with a result register: a
// half word gives 1 value, a Q8_0 data word 2, a Q4_0 data word 2 (the
// last of a block 18), a scale word none; a 9-word Q4_0 block gives 32.
// Any register write restarts the block position and element count.
module quantized_weight_dequantizer
    import qwd_pkg::*;
#(
    parameter int BLOCK_ELEMENTS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value_bits,
    output logic        end_of_item,
    output logic        end_of_tensor
);

    localparam int HALF = BLOCK_ELEMENTS / 2;
    localparam int HW   = $clog2(HALF + 2);

    fmt_t        fmt_reg;
    logic [31:0] count_reg;
    logic [4:0]  word_position_reg;
    logic [31:0] element_counter_reg;
    logic [15:0] block_scale_reg;
    logic [4*HALF-1:0] upper_nibbles_reg;

    logic        busy_reg;
    logic [15:0] word_reg;
    logic [HW-1:0] sub_reg;
    logic [HW-1:0] nsub_reg;
    logic [32:0] base_reg;
    logic        q4_reg;

    logic  conv_ready;
    elem_t elem;
    logic  emit_ok;
    logic  last_sub;
    logic [3:0] nib;
    logic [7:0] byte_sel;
    logic [4:0] last_pos;

    logic          issue;
    logic          issue_done;
    logic          accept;
    logic          block_end;
    logic [5:0]    k2;
    logic [32:0]   adv_one;
    logic [32:0]   adv_block;
    logic [32:0]   base_next;
    logic [HW-1:0] nsub_next;
    logic          busy_next;

    assign last_pos   = (fmt_reg == FMT_Q4) ? 5'(BLOCK_ELEMENTS / 4) : 5'(HALF);
    assign last_sub   = (sub_reg == nsub_reg - HW'(1));
    assign emit_ok    = busy_reg && (elem.index < 33'(count_reg));
    assign issue      = busy_reg && (!emit_ok || conv_ready);
    assign issue_done = issue && (last_sub || !emit_ok);
    assign in_ready   = !busy_reg || issue_done;
    assign accept     = in_valid && in_ready;
    assign block_end  = (word_position_reg >= last_pos);
    assign k2         = {word_position_reg - 5'd1, 1'b0};
    assign adv_one    = 33'(element_counter_reg) + 33'd1;
    assign adv_block  = 33'(element_counter_reg) + 33'(BLOCK_ELEMENTS);

    always_comb
    begin
        byte_sel = sub_reg[0] ? word_reg[15:8] : word_reg[7:0];
        nib = 4'd0;
        elem.scale = block_scale_reg;
        elem.last_of_word = 1'b0;
        elem.half = 1'b0;
        elem.index = base_reg + 33'(sub_reg);
        if (q4_reg)
        begin
            if (sub_reg < HW'(2))
            begin
                nib = byte_sel[3:0];
            end
            else
            begin
                nib = upper_nibbles_reg[4*(32'(sub_reg) - 2) +: 4];
            end
            elem.neg = (nib < 4'd8);
            elem.mag = elem.neg ? 8'(4'd8 - nib) : 8'(nib - 4'd8);
        end
        else if (fmt_reg == FMT_HALF)
        begin
            elem.scale = word_reg;
            elem.half = 1'b1;
            elem.neg = 1'b0;
            elem.mag = 8'd1;
        end
        else
        begin
            elem.neg = byte_sel[7];
            elem.mag = byte_sel[7] ? 8'(-byte_sel) : byte_sel;
        end
        if (last_sub)
        begin
            elem.last_of_word = 1'b1;
        end
        else
        begin
            elem.last_of_word = (elem.index + 33'd1 >= 33'(count_reg));
        end
    end

    always_comb
    begin
        base_next = 33'(element_counter_reg) + 33'(k2);
        nsub_next = HW'(2);
        busy_next = 1'b0;
        if (fmt_reg == FMT_HALF)
        begin
            base_next = 33'(element_counter_reg);
            nsub_next = HW'(1);
            busy_next = 1'b1;
        end
        else if (fmt_reg != FMT_NONE && word_position_reg != 5'd0)
        begin
            busy_next = 1'b1;
            if (fmt_reg == FMT_Q4 && block_end)
            begin
                nsub_next = HW'(HALF + 2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_HALF;
            count_reg <= 32'd1;
            word_position_reg <= 5'd0;
            element_counter_reg <= 32'd0;
            block_scale_reg <= 16'd0;
            upper_nibbles_reg <= '0;
            busy_reg <= 1'b0;
            word_reg <= 16'd0;
            sub_reg <= '0;
            nsub_reg <= '0;
            base_reg <= 33'd0;
            q4_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORMAT_MODE:   fmt_reg <= fmt_t'(cfg_data[1:0]);
                REG_ELEMENT_COUNT: count_reg <= cfg_data;
                default:           fmt_reg <= fmt_reg;
            endcase
            word_position_reg <= 5'd0;
            element_counter_reg <= 32'd0;
            block_scale_reg <= 16'd0;
            upper_nibbles_reg <= '0;
        end
        else if (accept)
        begin
            word_reg <= data_word;
            sub_reg  <= '0;
            q4_reg   <= (fmt_reg == FMT_Q4);
            base_reg <= base_next;
            nsub_reg <= nsub_next;
            busy_reg <= busy_next;
            if (fmt_reg == FMT_HALF)
            begin
                element_counter_reg <= adv_one[32] ? 32'hFFFFFFFF : adv_one[31:0];
            end
            else if (fmt_reg != FMT_NONE)
            begin
                if (word_position_reg == 5'd0)
                begin
                    block_scale_reg <= data_word;
                    word_position_reg <= 5'd1;
                end
                else
                begin
                    if (fmt_reg == FMT_Q4)
                    begin
                        upper_nibbles_reg[8*(32'(word_position_reg) - 1) +: 8]
                            <= {data_word[15:12], data_word[7:4]};
                    end
                    if (block_end)
                    begin
                        element_counter_reg <= adv_block[32] ? 32'hFFFFFFFF
                                                             : adv_block[31:0];
                        word_position_reg <= 5'd0;
                    end
                    else
                    begin
                        word_position_reg <= word_position_reg + 5'd1;
                    end
                end
            end
        end
        else if (issue)
        begin
            sub_reg <= sub_reg + HW'(1);
            if (issue_done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    qwd_convert u_convert (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (emit_ok && !cfg_we),
        .in_ready      (conv_ready),
        .elem          (elem),
        .count         (count_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value_bits    (value_bits),
        .end_of_item   (end_of_item),
        .end_of_tensor (end_of_tensor)
    );

endmodule
